### sv/kf_pkg.sv
// Shared types, constants and saturation helpers for the joint angle Kalman filter.
// No dependencies; imported by every module of the block.
`default_nettype none
package kf_pkg;

  typedef logic signed [31:0] q_t;     // Q16.16 value
  typedef logic signed [47:0] prod_t;  // Q32.16 product, floor-shifted
  typedef logic signed [49:0] wide_t;  // headroom for short sums
  typedef logic signed [32:0] var_t;   // innovation variance, exact

  localparam int DivBits = 48;         // dividend is |num| << 16
  localparam int CntW = 6;

  localparam wide_t QMax = 50'sd2147483647;
  localparam wide_t QMin = -50'sd2147483648;

  function automatic wide_t ext32(q_t v);
    return {{18{v[31]}}, v};
  endfunction

  function automatic wide_t ext48(prod_t v);
    return {{2{v[47]}}, v};
  endfunction

  function automatic q_t sat32(wide_t v);
    q_t r;
    if (v > QMax) begin
      r = 32'sh7fffffff;
    end else if (v < QMin) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### sv/kf_mul.sv
// Shared signed 32x32 multiplier with registered Q32.16 result (floor shift).
// Depends on kf_pkg.
`default_nettype none
module kf_mul import kf_pkg::*; (
  input  logic  clk,
  input  q_t    a,
  input  q_t    b,
  output prod_t prod
);

  logic signed [63:0] full;

  assign full = a * b;

  // arithmetic drop of 16 fraction bits is floor rounding
  always_ff @(posedge clk) begin
    prod <= full[63:16];
  end

endmodule
`default_nettype wire

### sv/kf_div.sv
// Iterative restoring divider for the Kalman gains: (num * 65536) / den,
// truncated toward zero, saturated; zero when den is not positive. Depends on kf_pkg.
`default_nettype none
module kf_div import kf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  q_t   num,
  input  var_t den,
  output logic done,
  output q_t   quot
);

  logic [DivBits-1:0] dvd;
  logic [31:0]        rem;
  logic [31:0]        dsr;
  logic [CntW-1:0]    cnt;
  logic               busy;
  logic               neg;
  logic               zero;

  logic [32:0] num_ext;
  logic [32:0] num_mag;
  logic [32:0] rem_sh;
  logic [32:0] rem_sub;
  logic        ge;

  assign num_ext = {num[31], num};
  assign num_mag = num[31] ? (33'd0 - num_ext) : num_ext;
  assign rem_sh  = {rem, dvd[DivBits-1]};
  assign rem_sub = rem_sh - {1'b0, dsr};
  assign ge      = rem_sh >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !start && busy && cnt == CntW'(DivBits - 1);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CntW'(DivBits - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd  <= {num_mag[31:0], 16'd0};
      rem  <= '0;
      dsr  <= den[31:0];
      cnt  <= '0;
      neg  <= num[31];
      zero <= (den[32] || den == '0);
    end else if (busy) begin
      rem <= ge ? rem_sub[31:0] : rem_sh[31:0];
      dvd <= {dvd[DivBits-2:0], ge};
      cnt <= cnt + CntW'(1);
    end
  end

  always_comb begin
    if (zero) begin
      quot = '0;
    end else if (neg) begin
      if (dvd > DivBits'(64'd2147483648)) begin
        quot = 32'sh80000000;
      end else begin
        quot = q_t'(32'd0 - dvd[31:0]);
      end
    end else begin
      if (dvd > DivBits'(64'd2147483647)) begin
        quot = 32'sh7fffffff;
      end else begin
        quot = dvd[31:0];
      end
    end
  end

endmodule
`default_nettype wire

### sv/joint_angle_kalman_filter.sv
// Joint angle Kalman filter: a two-state (angle, rate) constant-velocity filter.
// The next input beat is taken only once the previous result has been loaded;
// the two gain divides in kf_div take most of the time, the rest is one shared
// multiplier step per product; a result still stalled at the output holds the
// last step. Reset (rst, synchronous): state and covariance zero, step_time 655,
// noises 65536, no result.
`default_nettype none
module joint_angle_kalman_filter import kf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  q_t          measured_angle,
  output logic        out_valid,
  input  logic        out_stall,
  output q_t          angle_estimate,
  output q_t          rate_estimate,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data
);

  // register indexes
  localparam logic [1:0] CFG_STEP  = 2'd0;
  localparam logic [1:0] CFG_QNOISE = 2'd1;
  localparam logic [1:0] CFG_RNOISE = 2'd2;

  // sequencer states; most states consume the previous product and issue the next
  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_ISSUE = 5'd1;
  localparam logic [4:0] S_DT2  = 5'd2;
  localparam logic [4:0] S_DT3  = 5'd3;
  localparam logic [4:0] S_DT4  = 5'd4;
  localparam logic [4:0] S_Q4   = 5'd5;
  localparam logic [4:0] S_Q3   = 5'd6;
  localparam logic [4:0] S_Q2   = 5'd7;
  localparam logic [4:0] S_XA   = 5'd8;
  localparam logic [4:0] S_T    = 5'd9;
  localparam logic [4:0] S_M21  = 5'd10;
  localparam logic [4:0] S_PP   = 5'd11;
  localparam logic [4:0] S_DIV1 = 5'd12;
  localparam logic [4:0] S_DIV2 = 5'd13;
  localparam logic [4:0] S_KE   = 5'd14;
  localparam logic [4:0] S_N1   = 5'd15;
  localparam logic [4:0] S_N2   = 5'd16;
  localparam logic [4:0] S_C0   = 5'd17;
  localparam logic [4:0] S_C1   = 5'd18;
  localparam logic [4:0] S_C2   = 5'd19;
  localparam logic [4:0] S_C3   = 5'd20;

  logic [4:0]  st;
  logic [15:0] step_time;
  logic [30:0] process_noise;
  logic [30:0] measurement_noise;

  q_t   z, x1, x2, p11, p12, p21, p22;
  q_t   dt2, dt3, q4, q3, q2;
  q_t   xa, t12, t21, m21, pp11, pp12, pp21, pp22, e, k1, k2;
  q_t   pp11_next;
  var_t s;
  logic go;

  q_t    mul_a, mul_b, dt_q, qn_q;
  prod_t prod;
  logic  div_done;
  q_t    div_quot;
  q_t    div_num;
  logic  out_free;

  assign dt_q     = q_t'({16'd0, step_time});
  assign qn_q     = q_t'({1'b0, process_noise});
  assign in_stall = (st != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign div_num  = (st == S_DIV2) ? pp21 : pp11;
  assign pp11_next = sat32(ext32(p11) + ext32(m21) + ext48(prod) + ext32(q4));

  kf_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  kf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (go),
    .num   (div_num),
    .den   (s),
    .done  (div_done),
    .quot  (div_quot)
  );

  // operand select for the shared multiplier
  always_comb begin
    mul_a = dt_q;
    mul_b = dt_q;
    case (st)
      S_ISSUE: begin mul_a = dt_q;      mul_b = dt_q; end
      S_DT2:   begin mul_a = prod[31:0]; mul_b = dt_q; end
      S_DT3:   begin mul_a = prod[31:0]; mul_b = dt_q; end
      S_DT4:   begin mul_a = qn_q;      mul_b = prod[31:0]; end
      S_Q4:    begin mul_a = qn_q;      mul_b = dt3; end
      S_Q3:    begin mul_a = qn_q;      mul_b = dt2; end
      S_Q2:    begin mul_a = x2;        mul_b = dt_q; end
      S_XA:    begin mul_a = dt_q;      mul_b = p22; end
      S_T:     begin mul_a = dt_q;      mul_b = p21; end
      S_M21:   begin mul_a = dt_q;      mul_b = t12; end
      S_KE:    begin mul_a = k1;        mul_b = e; end
      S_N1:    begin mul_a = k2;        mul_b = e; end
      S_N2:    begin mul_a = k1;        mul_b = pp11; end
      S_C0:    begin mul_a = k1;        mul_b = pp12; end
      S_C1:    begin mul_a = k2;        mul_b = pp11; end
      S_C2:    begin mul_a = k2;        mul_b = pp12; end
      S_C3:    begin mul_a = k2;        mul_b = pp12; end  // hold product while output blocked
      default: begin mul_a = dt_q;      mul_b = dt_q; end
    endcase
  end

  // configuration registers; the user must write them only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      step_time         <= 16'd655;
      process_noise     <= 31'd65536;
      measurement_noise <= 31'd65536;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_STEP:   step_time         <= cfg_data[15:0];
        CFG_QNOISE: process_noise     <= cfg_data;
        CFG_RNOISE: measurement_noise <= cfg_data;
        default:    ;  // drop writes beyond the register list
      endcase
    end
  end

  // sequencer and control
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      go        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // pulse a divide start after the prediction and after the first gain
      go <= (st == S_PP) || (st == S_DIV1 && div_done);
      if (st == S_C3 && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (st)
        S_IDLE: begin
          if (in_valid) begin
            st <= S_ISSUE;
          end
        end
        S_PP: begin
          st <= S_DIV1;
        end
        S_DIV1: begin
          if (div_done) begin
            st <= S_DIV2;
          end
        end
        S_DIV2: begin
          if (div_done) begin
            st <= S_KE;
          end
        end
        S_C3: begin
          if (out_free) begin
            st <= S_IDLE;
          end
        end
        default: begin
          st <= st + 5'd1;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      x1  <= '0;
      x2  <= '0;
      p11 <= '0;
      p12 <= '0;
      p21 <= '0;
      p22 <= '0;
    end else begin
      case (st)
        S_IDLE: begin
          if (in_valid) begin
            z <= measured_angle;
          end
        end
        S_DT2: dt2 <= prod[31:0];
        S_DT3: dt3 <= prod[31:0];
        S_Q4:  q4  <= prod[33:2];
        S_Q3:  q3  <= prod[32:1];
        S_Q2:  q2  <= prod[31:0];
        S_XA:  xa  <= sat32(ext32(x1) + ext48(prod));
        S_T: begin
          t12 <= sat32(ext32(p12) + ext48(prod));
          t21 <= sat32(ext32(p21) + ext48(prod));
        end
        S_M21: m21 <= prod[31:0];
        S_PP: begin
          pp11 <= pp11_next;
          pp12 <= sat32(ext32(t12) + ext32(q3));
          pp21 <= sat32(ext32(t21) + ext32(q3));
          pp22 <= sat32(ext32(p22) + ext32(q2));
          // exact innovation variance, ready when the first divide starts
          s    <= {pp11_next[31], pp11_next} + {2'b00, measurement_noise};
          e    <= sat32(ext32(z) - ext32(xa));
        end
        S_DIV1: begin
          if (div_done) begin
            k1 <= div_quot;
          end
        end
        S_DIV2: begin
          if (div_done) begin
            k2 <= div_quot;
          end
        end
        S_N1:  x1  <= sat32(ext32(xa) + ext48(prod));
        S_N2:  x2  <= sat32(ext32(x2) + ext48(prod));
        S_C0:  p11 <= sat32(ext32(pp11) - ext48(prod));
        S_C1:  p12 <= sat32(ext32(pp12) - ext48(prod));
        S_C2:  p21 <= sat32(ext32(pp21) - ext48(prod));
        S_C3: begin
          if (out_free) begin
            p22 <= sat32(ext32(pp22) - ext48(prod));
          end
        end
        default: ;
      endcase
    end
  end

  // result register; load once the estimates are final
  always_ff @(posedge clk) begin
    if (st == S_C3 && out_free) begin
      angle_estimate <= x1;
      rate_estimate  <= x2;
    end
  end

endmodule
`default_nettype wire

### sv/kf_checker.sv
// Port-level checks for the joint angle Kalman filter, bound to the top level.
// Depends on kf_pkg and joint_angle_kalman_filter.
`default_nettype none
module kf_checker import kf_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input q_t          angle_estimate,
  input q_t          rate_estimate
);

  // busy right after taking a beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accept");

  // a new result only comes out of a running item
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without work");

  // nothing pending after reset
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("reset did not clear");

  // held result beat does not change
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(angle_estimate)
      && $stable(rate_estimate))
    else $error("stalled result changed");

endmodule

bind joint_angle_kalman_filter kf_checker u_kf_checker (.*);
`default_nettype wire
